[hw/rtl/generational_handle_table_macros.svh]
// Assertion macros; the clock and reset of the asserting module are named clock and reset.
`ifndef GENERATIONAL_HANDLE_TABLE_MACROS_SVH
`define GENERATIONAL_HANDLE_TABLE_MACROS_SVH

`ifndef SYNTHESIS
`define GHT_ASSERT_ALWAYS(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("invariant violated");
`define GHT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sequence violated");
`else
`define GHT_ASSERT_ALWAYS(label, expr)
`define GHT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[hw/rtl/ght_pkg.sv]
package ght_pkg;

   localparam int SLOT_COUNT_DEFAULT = 256;
   localparam int SLOT_FIELD_W       = 8;
   localparam int INC_W              = 32;

   localparam logic [INC_W-1:0] INC_MAX   = '1;
   localparam logic [INC_W-1:0] INC_RESET = INC_W'(1);

   localparam logic [2:0] KIND_ADOPT    = 3'd0;
   localparam logic [2:0] KIND_RELEASE  = 3'd1;
   localparam logic [2:0] KIND_CONTAINS = 3'd2;
   localparam logic [2:0] KIND_IDENTITY = 3'd3;
   localparam logic [2:0] KIND_MERGE    = 3'd4;
   localparam logic [2:0] KIND_CLEAR    = 3'd5;

   typedef struct packed {
      logic [2:0]              kind;
      logic [SLOT_FIELD_W-1:0] slot;
      logic [INC_W-1:0]        incarnation;
      logic [INC_W-1:0]        next_value;
   } req_type;

   typedef struct packed {
      logic                    ok;
      logic [SLOT_FIELD_W-1:0] handle_slot;
      logic [INC_W-1:0]        handle_incarnation;
      logic [SLOT_FIELD_W-1:0] active_count;
      logic                    exhausted;
   } rsp_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic load;
      logic exec;
   } cmd_type;

endpackage

[hw/rtl/generational_handle_table.sv]
// Generational handle table: SLOT_COUNT slots, each holding a 32-bit
// incarnation (0 = free); slot 0 is never handed out.
// Request channel: req_data carries kind, slot, incarnation and next_value
// and transfers on a rising edge with start high and busy low.
// Response channel: rsp_data is valid for exactly one cycle while
// rsp_strobe is high; the receiver cannot stall, so every result must be
// taken in that cycle. Exactly one response follows each request.
// The response is registered: rsp_strobe and rsp_data are loaded at the end of
// the execute cycle. A request has an accept cycle, which reads the slot table,
// and an execute cycle, which does the update and the one write port access.
// busy is high during the execute cycle only, so the next request is taken
// while the previous response is on the ports.
// Clear empties the whole table within its execute cycle through per-slot
// valid flops. Reset (synchronous) frees every slot, sets the
// incarnation counter to 1 and the active count to 0, with no clearing pass.
module generational_handle_table #(
   parameter int SLOT_COUNT = ght_pkg::SLOT_COUNT_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ght_pkg::req_type req_data,
   output logic             rsp_strobe,
   output ght_pkg::rsp_type rsp_data
);

   ght_pkg::cmd_type cmd;

   ght_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   ght_datapath #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

[hw/rtl/ght_ctrl.sv]
module ght_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output ght_pkg::cmd_type cmd
);

   ght_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ght_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ght_pkg::ST_IDLE: begin
            if (start) begin
               state_in = ght_pkg::ST_EXEC;
            end
         end
         ght_pkg::ST_EXEC: begin
            state_in = ght_pkg::ST_IDLE;
         end
         default: begin
            state_in = ght_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy     = 1'b0;
      cmd.load = 1'b0;
      cmd.exec = 1'b0;
      case (state_ff)
         ght_pkg::ST_IDLE: begin
            cmd.load = start;
         end
         ght_pkg::ST_EXEC: begin
            busy     = 1'b1;
            cmd.exec = 1'b1;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

endmodule

[hw/rtl/ght_datapath.sv]
`include "generational_handle_table_macros.svh"

module ght_datapath #(
   parameter int SLOT_COUNT = ght_pkg::SLOT_COUNT_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  ght_pkg::cmd_type cmd,
   input  ght_pkg::req_type req_data,
   output logic             rsp_strobe,
   output ght_pkg::rsp_type rsp_data
);

   localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam logic [ght_pkg::SLOT_FIELD_W:0] SLOT_LIMIT =
      (ght_pkg::SLOT_FIELD_W + 1)'(SLOT_COUNT);

   logic [ght_pkg::INC_W-1:0] mem [SLOT_COUNT];

   ght_pkg::req_type                req_ff;
   logic [ght_pkg::INC_W-1:0]       rd_data_ff;
   logic                            rd_valid_ff;
   logic [SLOT_COUNT-1:0]           valid_ff, valid_in;
   logic [ght_pkg::INC_W-1:0]       counter_ff, counter_in;
   logic [ght_pkg::SLOT_FIELD_W-1:0] count_ff, count_in;
   ght_pkg::rsp_type                rsp_ff, rsp_in;
   logic                            rsp_strobe_ff;

   logic                      usable;
   logic [SLOT_W-1:0]         idx;
   logic [ght_pkg::INC_W-1:0] stored;
   logic                      mem_we;

   // table port: read at accept, write during execute
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[idx] <= counter_ff;
      end
      if (cmd.load) begin
         rd_data_ff  <= mem[req_data.slot[SLOT_W-1:0]];
         rd_valid_ff <= valid_ff[req_data.slot[SLOT_W-1:0]];
         req_ff      <= req_data;
      end
   end

   always_comb begin
      idx    = req_ff.slot[SLOT_W-1:0];
      usable = (req_ff.slot != '0) && ({1'b0, req_ff.slot} < SLOT_LIMIT);
      stored = rd_valid_ff ? rd_data_ff : '0;

      valid_in   = valid_ff;
      counter_in = counter_ff;
      count_in   = count_ff;
      mem_we     = 1'b0;

      rsp_in                    = '0;
      case (req_ff.kind)
         ght_pkg::KIND_ADOPT: begin
            if (usable && (stored == '0) && (counter_ff != '0)) begin
               mem_we                    = cmd.exec;
               valid_in[idx]             = 1'b1;
               count_in                  = count_ff + 1'b1;
               counter_in                = (counter_ff == ght_pkg::INC_MAX) ? '0
                                                                           : counter_ff + 1'b1;
               rsp_in.ok                 = 1'b1;
               rsp_in.handle_slot        = req_ff.slot;
               rsp_in.handle_incarnation = counter_ff;
            end
         end
         ght_pkg::KIND_RELEASE: begin
            if (usable && (req_ff.incarnation != '0) && (stored == req_ff.incarnation)) begin
               valid_in[idx] = 1'b0;
               count_in      = count_ff - 1'b1;
               rsp_in.ok     = 1'b1;
            end
         end
         ght_pkg::KIND_CONTAINS: begin
            rsp_in.ok = usable && (req_ff.incarnation != '0) &&
                        (stored == req_ff.incarnation);
         end
         ght_pkg::KIND_IDENTITY: begin
            if (usable && (stored != '0)) begin
               rsp_in.ok                 = 1'b1;
               rsp_in.handle_slot        = req_ff.slot;
               rsp_in.handle_incarnation = stored;
            end
         end
         ght_pkg::KIND_MERGE: begin
            if ((counter_ff == '0) || (req_ff.next_value == '0)) begin
               counter_in = '0;
            end else if (req_ff.next_value > counter_ff) begin
               counter_in = req_ff.next_value;
            end
            rsp_in.ok = 1'b1;
         end
         ght_pkg::KIND_CLEAR: begin
            valid_in  = '0;
            count_in  = '0;
            rsp_in.ok = 1'b1;
         end
         default: begin
            rsp_in.ok = 1'b0;
         end
      endcase
      rsp_in.active_count = count_in;
      rsp_in.exhausted    = (counter_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         counter_ff    <= ght_pkg::INC_RESET;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.exec;
         if (cmd.exec) begin
            valid_ff   <= valid_in;
            counter_ff <= counter_in;
            count_ff   <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   `GHT_ASSERT_ALWAYS(a_count_matches_valid,
      $countones(valid_ff) == int'(count_ff))
   `GHT_ASSERT_ALWAYS(a_slot_zero_unused, !valid_ff[0])
   `GHT_ASSERT_NEXT(a_exhausted_sticks, counter_ff == '0, counter_ff == '0)
   `GHT_ASSERT_NEXT(a_result_follows_exec, cmd.exec, rsp_strobe_ff && !cmd.exec)

endmodule

[test/generational_handle_table_tb.sv]
module generational_handle_table_tb;

   localparam int SLOTS       = ght_pkg::SLOT_COUNT_DEFAULT;
   localparam int WORD_W      = ght_pkg::INC_W;
   localparam int SLOT_W      = ght_pkg::SLOT_FIELD_W;
   localparam int STALL_LIMIT = 2000;
   localparam int REPORT_MAX  = 10;

   localparam logic [2:0] KIND_RSVD_A = 3'd6;
   localparam logic [2:0] KIND_RSVD_B = 3'd7;

   logic             clock    = 1'b0;
   logic             reset    = 1'b1;
   logic             start    = 1'b0;
   ght_pkg::req_type req_data = '0;
   logic             busy;
   logic             rsp_strobe;
   ght_pkg::rsp_type rsp_data;

   logic [WORD_W-1:0] model_inc [SLOTS];
   logic [WORD_W-1:0] model_next;
   logic [SLOT_W-1:0] model_live;

   ght_pkg::rsp_type pending_rsp [$];
   int               mismatch_count = 0;
   int               idle_cycles    = 0;
   bit               gaps_on        = 1'b1;

   generational_handle_table DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic void table_reset();
      foreach (model_inc[i]) model_inc[i] = '0;
      model_next = ght_pkg::INC_RESET;
      model_live = '0;
   endfunction

   function automatic bit handle_live(logic [SLOT_W-1:0] s, logic [WORD_W-1:0] inc);
      return s != 0 && int'(s) < SLOTS && inc != 0 && model_inc[s] == inc;
   endfunction

   // updates the table copy and returns the response the block must give
   function automatic ght_pkg::rsp_type predict_table_response(ght_pkg::req_type r);
      ght_pkg::rsp_type o;
      bit               usable;
      o      = '0;
      usable = r.slot != 0 && int'(r.slot) < SLOTS;
      case (r.kind)
         ght_pkg::KIND_ADOPT: begin
            if (usable && model_inc[r.slot] == 0 && model_next != 0) begin
               model_inc[r.slot]    = model_next;
               o.ok                 = 1'b1;
               o.handle_slot        = r.slot;
               o.handle_incarnation = model_next;
               model_next           = (model_next == ght_pkg::INC_MAX) ? '0
                                                                       : model_next + 1;
               model_live           = model_live + 1'b1;
            end
         end
         ght_pkg::KIND_RELEASE: begin
            if (handle_live(r.slot, r.incarnation)) begin
               model_inc[r.slot] = '0;
               model_live        = model_live - 1'b1;
               o.ok              = 1'b1;
            end
         end
         ght_pkg::KIND_CONTAINS: o.ok = handle_live(r.slot, r.incarnation);
         ght_pkg::KIND_IDENTITY: begin
            if (usable && model_inc[r.slot] != 0) begin
               o.ok                 = 1'b1;
               o.handle_slot        = r.slot;
               o.handle_incarnation = model_inc[r.slot];
            end
         end
         ght_pkg::KIND_MERGE: begin
            if (model_next == 0 || r.next_value == 0)
               model_next = '0;
            else if (r.next_value > model_next)
               model_next = r.next_value;
            o.ok = 1'b1;
         end
         ght_pkg::KIND_CLEAR: begin
            foreach (model_inc[i]) model_inc[i] = '0;
            model_live = '0;
            o.ok       = 1'b1;
         end
         default: ;
      endcase
      o.active_count = model_live;
      o.exhausted    = model_next == 0;
      return o;
   endfunction

   function automatic int pick_occupied();
      int taken [$];
      for (int i = 1; i < SLOTS; i++)
         if (model_inc[i] != 0) taken.push_back(i);
      if (taken.size() == 0) return 0;
      return taken[$urandom_range(taken.size() - 1)];
   endfunction

   // never close enough to the top for random traffic to exhaust the counter
   function automatic logic [WORD_W-1:0] merge_word();
      logic [WORD_W-1:0] w;
      w = ($urandom_range(1) == 0) ? WORD_W'($urandom_range(2000, 1))
                                   : WORD_W'($urandom);
      if (w == 0 || w > 32'hFFF0_0000) w = {1'b0, w[WORD_W-2:1], 1'b1};
      return w;
   endfunction

   task automatic log_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX) $display("%0t: %s", $time, msg);
   endtask

   task automatic idle_gap();
      int roll;
      int n;
      roll = $urandom_range(99);
      n    = 0;
      if (gaps_on) begin
         if (roll >= 90)      n = $urandom_range(40, 5);
         else if (roll >= 55) n = $urandom_range(3, 1);
      end
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // one transfer on the request side, then a random gap
   task automatic send_op(logic [2:0] kind, int slot, logic [WORD_W-1:0] inc,
                          logic [WORD_W-1:0] nv);
      ght_pkg::req_type r;
      r.kind        = kind;
      r.slot        = SLOT_W'(slot);
      r.incarnation = inc;
      r.next_value  = nv;
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_rsp.push_back(predict_table_response(r));
      idle_gap();
   endtask

   always @(posedge clock) begin
      ght_pkg::rsp_type want;
      if ((start && !busy) || rsp_strobe)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("FAIL generational_handle_table");
         $finish;
      end
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_rsp.size() == 0) begin
            log_mismatch("response with none outstanding");
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.ok !== want.ok || rsp_data.handle_slot !== want.handle_slot ||
                rsp_data.handle_incarnation !== want.handle_incarnation ||
                rsp_data.active_count !== want.active_count ||
                rsp_data.exhausted !== want.exhausted)
               log_mismatch($sformatf(
                  "ok %b/%b slot %0d/%0d inc %h/%h count %0d/%0d exhausted %b/%b (exp/got)",
                  want.ok, rsp_data.ok, want.handle_slot, rsp_data.handle_slot,
                  want.handle_incarnation, rsp_data.handle_incarnation,
                  want.active_count, rsp_data.active_count,
                  want.exhausted, rsp_data.exhausted));
         end
      end
   end

   task automatic test_slot_zero();
      send_op(ght_pkg::KIND_ADOPT, 0, $urandom, $urandom);
      send_op(ght_pkg::KIND_IDENTITY, 0, $urandom, $urandom);
      send_op(ght_pkg::KIND_CONTAINS, 0, 32'd1, $urandom);
      send_op(ght_pkg::KIND_RELEASE, 0, 32'd1, $urandom);
      send_op(KIND_RSVD_A, $urandom_range(255), $urandom, $urandom);
      send_op(KIND_RSVD_B, $urandom_range(255), $urandom, $urandom);
   endtask

   task automatic test_handle_lifecycle();
      send_op(ght_pkg::KIND_ADOPT, 1, '0, '0);
      send_op(ght_pkg::KIND_ADOPT, 255, ght_pkg::INC_MAX, ght_pkg::INC_MAX);
      send_op(ght_pkg::KIND_ADOPT, 1, $urandom, $urandom);
      send_op(ght_pkg::KIND_IDENTITY, 1, '0, '0);
      send_op(ght_pkg::KIND_CONTAINS, 1, model_inc[1], '0);
      send_op(ght_pkg::KIND_CONTAINS, 1, '0, '0);
      send_op(ght_pkg::KIND_CONTAINS, 1, model_inc[1] + 1, '0);
      send_op(ght_pkg::KIND_RELEASE, 1, model_inc[1] + 1, '0);
      send_op(ght_pkg::KIND_RELEASE, 1, '0, '0);
      send_op(ght_pkg::KIND_RELEASE, 1, model_inc[1], '0);
      send_op(ght_pkg::KIND_IDENTITY, 1, '0, '0);
      send_op(ght_pkg::KIND_CONTAINS, 1, 32'd1, '0);
      send_op(ght_pkg::KIND_MERGE, 0, '0, 32'd1000);
      send_op(ght_pkg::KIND_MERGE, 0, '0, 32'd3);
      send_op(ght_pkg::KIND_ADOPT, 128, '0, '0);
      send_op(ght_pkg::KIND_CLEAR, 0, '0, '0);
      send_op(ght_pkg::KIND_IDENTITY, 255, '0, '0);
   endtask

   task automatic test_fill_table();
      gaps_on = 1'b0;
      send_op(ght_pkg::KIND_CLEAR, 0, $urandom, $urandom);
      for (int s = 1; s < SLOTS; s++)
         send_op(ght_pkg::KIND_ADOPT, s, $urandom, $urandom);
      gaps_on = 1'b1;
      send_op(ght_pkg::KIND_ADOPT, $urandom_range(255, 1), $urandom, $urandom);
      send_op(ght_pkg::KIND_IDENTITY, 255, '0, '0);
      for (int s = 1; s < SLOTS; s += 3)
         send_op(ght_pkg::KIND_RELEASE, s, model_inc[s], $urandom);
      send_op(ght_pkg::KIND_CLEAR, 0, $urandom, $urandom);
   endtask

   task automatic test_random_traffic(int n);
      int                roll;
      int                s;
      logic [WORD_W-1:0] inc;
      for (int i = 0; i < n; i++) begin
         if (i % 150 == 0) gaps_on = $urandom_range(3) != 0;
         roll = $urandom_range(99);
         s    = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(255);
         inc  = $urandom;
         if (roll < 35) begin
            send_op(ght_pkg::KIND_ADOPT, s, inc, $urandom);
         end else if (roll < 65) begin
            if ($urandom_range(4) != 0 && pick_occupied() != 0) begin
               s = pick_occupied();
               case ($urandom_range(9))
                  0:       inc = model_inc[s] + 1;
                  1:       inc = '0;
                  default: inc = model_inc[s];
               endcase
            end
            send_op((roll < 50) ? ght_pkg::KIND_RELEASE : ght_pkg::KIND_CONTAINS,
                    s, inc, $urandom);
         end else if (roll < 82) begin
            send_op(ght_pkg::KIND_IDENTITY, s, inc, $urandom);
         end else if (roll < 92) begin
            send_op(ght_pkg::KIND_MERGE, s, inc, merge_word());
         end else if (roll < 94) begin
            send_op(ght_pkg::KIND_CLEAR, s, inc, $urandom);
         end else begin
            send_op(($urandom_range(1) == 0) ? KIND_RSVD_A : KIND_RSVD_B, s, inc, $urandom);
         end
      end
   endtask

   // the counter never recovers from zero, so this runs last
   task automatic test_exhaustion();
      send_op(ght_pkg::KIND_CLEAR, 0, '0, '0);
      send_op(ght_pkg::KIND_MERGE, 0, '0, ght_pkg::INC_MAX - 1);
      send_op(ght_pkg::KIND_ADOPT, 10, '0, '0);
      send_op(ght_pkg::KIND_ADOPT, 20, '0, '0);
      send_op(ght_pkg::KIND_ADOPT, 30, '0, '0);
      send_op(ght_pkg::KIND_MERGE, 0, '0, 32'd7);
      send_op(ght_pkg::KIND_MERGE, 0, '0, '0);
      send_op(ght_pkg::KIND_IDENTITY, 20, '0, '0);
      send_op(ght_pkg::KIND_CONTAINS, 20, ght_pkg::INC_MAX, '0);
      send_op(ght_pkg::KIND_RELEASE, 20, ght_pkg::INC_MAX, '0);
      send_op(ght_pkg::KIND_ADOPT, 20, '0, '0);
      send_op(ght_pkg::KIND_CLEAR, 0, '0, '0);
   endtask

   initial begin
      table_reset();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_slot_zero();
      test_handle_lifecycle();
      test_fill_table();
      test_random_traffic(750);
      test_exhaustion();
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      if (mismatch_count == 0 && pending_rsp.size() == 0)
         $display("PASS generational_handle_table");
      else
         $display("FAIL generational_handle_table");
      $finish;
   end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/ght_pkg.sv
hw/rtl/ght_ctrl.sv
hw/rtl/ght_datapath.sv
hw/rtl/generational_handle_table.sv
test/generational_handle_table_tb.sv
